@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the arc point generator RTL.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define APG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define APG_ASSERT(lbl, expr, msg)
`define APG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ hw/rtl/apg_pkg.sv @@
// Package for the arc point generator: widths, codes, control struct and
// the CORDIC arctangent table. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package apg_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int MAX_HALF_POINTS = 31;
  localparam int CORDIC_STEPS    = 18;
  localparam int ITER_BITS       = $clog2(CORDIC_STEPS);
  localparam int RADIUS_BITS     = 23;
  localparam int RCNT_BITS       = $clog2(RADIUS_BITS);
  localparam int GAIN_BITS       = 30;
  localparam int PROD_BITS       = RADIUS_BITS + GAIN_BITS;
  localparam int GAIN_SHIFT      = 16;
  localparam int G_BITS          = PROD_BITS - GAIN_SHIFT;
  localparam int DW              = 40;
  localparam int ROUND_BITS      = 14;
  localparam int COORD_BITS      = 24;
  localparam int SPAN_BITS       = 16;
  localparam int HP_BITS         = 5;
  localparam int IDX_BITS        = 6;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 23;
  localparam int TURN_BITS       = 32;

  localparam logic [GAIN_BITS-1:0] GAIN_Q30 = GAIN_BITS'(652032874);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ARC_RADIUS,
    CFG_HALF_SPAN,
    CFG_STEP_ANGLE,
    CFG_HALF_POINTS
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_LOAD,
    ST_ITER,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 load;
    logic                 step;
    logic [ITER_BITS-1:0] iter;
  } cordic_ctrl_t;

  function automatic logic [TURN_BITS-1:0] atan_turn(input logic [ITER_BITS-1:0] i);
    logic [TURN_BITS-1:0] a;
    case (i)
      ITER_BITS'(0):  a = 32'd536870912;
      ITER_BITS'(1):  a = 32'd316933406;
      ITER_BITS'(2):  a = 32'd167458907;
      ITER_BITS'(3):  a = 32'd85004756;
      ITER_BITS'(4):  a = 32'd42667331;
      ITER_BITS'(5):  a = 32'd21354465;
      ITER_BITS'(6):  a = 32'd10679838;
      ITER_BITS'(7):  a = 32'd5340245;
      ITER_BITS'(8):  a = 32'd2670163;
      ITER_BITS'(9):  a = 32'd1335087;
      ITER_BITS'(10): a = 32'd667544;
      ITER_BITS'(11): a = 32'd333772;
      ITER_BITS'(12): a = 32'd166886;
      ITER_BITS'(13): a = 32'd83443;
      ITER_BITS'(14): a = 32'd41722;
      ITER_BITS'(15): a = 32'd20861;
      ITER_BITS'(16): a = 32'd10430;
      ITER_BITS'(17): a = 32'd5215;
      default:        a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/apg_cordic.sv @@
// Shared CORDIC rotation unit: quadrant preload and one micro-rotation per beat
// of its step control. Depends on apg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module apg_cordic (
  input  logic                                 clk,
  input  apg_pkg::cordic_ctrl_t                ctrl,
  input  logic        [apg_pkg::G_BITS-1:0]    gain,
  input  logic        [apg_pkg::ANGLE_BITS-1:0] angle,
  output logic signed [apg_pkg::DW-1:0]        x_o,
  output logic signed [apg_pkg::DW-1:0]        y_o
);

  localparam int TB = apg_pkg::TURN_BITS;
  localparam int DW = apg_pkg::DW;

  logic        [TB-1:0] turn;
  logic        [TB-1:0] turn_q;
  logic        [1:0]    quad;
  logic signed [TB-1:0] z_init;
  logic signed [DW-1:0] g_s;
  logic signed [DW-1:0] x_init;
  logic signed [DW-1:0] y_init;
  logic signed [DW-1:0] x_r, x_nxt;
  logic signed [DW-1:0] y_r, y_nxt;
  logic signed [TB-1:0] z_r, z_nxt;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic signed [TB-1:0] da;

  assign turn   = {angle, {(TB - apg_pkg::ANGLE_BITS){1'b0}}};
  assign turn_q = turn + {2'b00, 1'b1, {(TB - 3){1'b0}}};
  assign quad   = turn_q[TB-1:TB-2];
  assign z_init = $signed(turn - {quad, {(TB - 2){1'b0}}});
  assign g_s    = $signed({{(DW - apg_pkg::G_BITS){1'b0}}, gain});

  always_comb begin
    case (quad)
      2'd0: begin
        x_init = g_s;
        y_init = '0;
      end
      2'd1: begin
        x_init = '0;
        y_init = g_s;
      end
      2'd2: begin
        x_init = -g_s;
        y_init = '0;
      end
      default: begin
        x_init = '0;
        y_init = -g_s;
      end
    endcase
  end

  assign dx = y_r >>> ctrl.iter;
  assign dy = x_r >>> ctrl.iter;
  assign da = $signed(apg_pkg::atan_turn(ctrl.iter));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (ctrl.load) begin
      x_nxt = x_init;
      y_nxt = y_init;
      z_nxt = z_init;
    end else if (ctrl.step) begin
      if (!z_r[TB-1]) begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - da;
      end else begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + da;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o = x_r;
  assign y_o = y_r;

endmodule
`default_nettype wire

@@ hw/rtl/arc_point_generator.sv @@
// Arc point generator top level: configuration registers, sequencer, serial
// gain multiply and output register. Depends on apg_pkg, apg_cordic and assert_macros.svh.
// An item runs the serial gain multiply, then for each of its 2N + 1 points one preload,
// 18 CORDIC micro-rotations on the shared unit and one emit beat. A new item is taken
// only in idle, after the last point of the previous item has been emitted; a stalled
// output holds the emit state.
// Reset clears the sequencer, the output valid and the configuration registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module arc_point_generator (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic        [apg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic        [apg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic        [apg_pkg::SPAN_BITS-1:0]      in_start_angle,
  input  logic signed [apg_pkg::COORD_BITS-1:0]     in_center_x,
  input  logic signed [apg_pkg::COORD_BITS-1:0]     in_center_y,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [apg_pkg::COORD_BITS-1:0]     out_point_x,
  output logic signed [apg_pkg::COORD_BITS-1:0]     out_point_y,
  output logic        [apg_pkg::IDX_BITS-1:0]       out_point_index,
  output logic                                      out_last_point
);

  localparam int AB = apg_pkg::ANGLE_BITS;
  localparam int DW = apg_pkg::DW;
  localparam int CB = apg_pkg::COORD_BITS;
  localparam int PB = apg_pkg::PROD_BITS;
  localparam int HB = apg_pkg::HP_BITS;
  localparam logic signed [DW-1:0] ROUND_HALF = DW'(1 << (apg_pkg::ROUND_BITS - 1));
  localparam logic signed [DW:0]   COORD_MAX  = (DW + 1)'((1 << (CB - 1)) - 1);
  localparam logic signed [DW:0]   COORD_MIN  = -((DW + 1)'(1 << (CB - 1)));
  localparam logic [AB-1:0]        EIGHTH     = AB'(1 << (AB - 3));
  localparam logic [HB-1:0]        HP_MAX     = HB'(apg_pkg::MAX_HALF_POINTS);

  function automatic logic signed [CB-1:0] sat_coord(input logic signed [DW:0] v);
    logic signed [CB-1:0] r;
    if (v > COORD_MAX) begin
      r = {1'b0, {(CB - 1){1'b1}}};
    end else if (v < COORD_MIN) begin
      r = {1'b1, {(CB - 1){1'b0}}};
    end else begin
      r = v[CB-1:0];
    end
    return r;
  endfunction

  logic [apg_pkg::RADIUS_BITS-1:0] radius_r;
  logic [apg_pkg::SPAN_BITS-1:0]   half_span_r;
  logic [apg_pkg::SPAN_BITS-1:0]   step_r;
  logic [HB-1:0]                   half_points_r;

  apg_pkg::state_t       state_r, state_nxt;
  apg_pkg::cordic_ctrl_t cctl;
  logic [apg_pkg::ITER_BITS-1:0] iter_r, iter_nxt;
  logic [apg_pkg::RCNT_BITS-1:0] mul_cnt_r;
  logic [PB-1:0]                 mul_acc_r;
  logic [PB-1:0]                 mcand_r;
  logic [apg_pkg::RADIUS_BITS-1:0] mplier_r;
  logic [AB-1:0]                 angle_r;
  logic signed [CB-1:0]          cx_r;
  logic signed [CB-1:0]          cy_r;
  logic [apg_pkg::IDX_BITS-1:0]  point_cnt_r;

  logic                          out_valid_r;
  logic signed [CB-1:0]          out_x_r;
  logic signed [CB-1:0]          out_y_r;
  logic [apg_pkg::IDX_BITS-1:0]  out_idx_r;
  logic                          out_last_r;

  logic [HB-1:0]                 n_eff;
  logic [apg_pkg::IDX_BITS-1:0]  last_idx;
  logic                          point_last;
  logic                          in_fire;
  logic                          emit_fire;
  logic                          mul_done;
  logic signed [DW-1:0]          cx_o;
  logic signed [DW-1:0]          cy_o;
  logic signed [DW-1:0]          rx;
  logic signed [DW-1:0]          ry;
  logic signed [DW-1:0]          ox;
  logic signed [DW-1:0]          oy;
  logic signed [DW:0]            sum_x;
  logic signed [DW:0]            sum_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= '0;
      half_span_r   <= '0;
      step_r        <= '0;
      half_points_r <= HB'(1);
    end else if (cfg_valid) begin
      unique case (apg_pkg::cfg_reg_t'(cfg_index))
        apg_pkg::CFG_ARC_RADIUS:  radius_r      <= cfg_data[apg_pkg::RADIUS_BITS-1:0];
        apg_pkg::CFG_HALF_SPAN:   half_span_r   <= cfg_data[apg_pkg::SPAN_BITS-1:0];
        apg_pkg::CFG_STEP_ANGLE:  step_r        <= cfg_data[apg_pkg::SPAN_BITS-1:0];
        apg_pkg::CFG_HALF_POINTS: half_points_r <= cfg_data[HB-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff      = (half_points_r > HP_MAX) ? HP_MAX : half_points_r;
  assign last_idx   = {n_eff, 1'b0};
  assign point_last = (point_cnt_r == last_idx);
  assign in_ready   = (state_r == apg_pkg::ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign mul_done   = (mul_cnt_r == apg_pkg::RCNT_BITS'(apg_pkg::RADIUS_BITS - 1));

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cctl      = '0;
    cctl.iter = iter_r;
    emit_fire = 1'b0;
    unique case (state_r)
      apg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = apg_pkg::ST_MULT;
        end
      end
      apg_pkg::ST_MULT: begin
        if (mul_done) begin
          state_nxt = apg_pkg::ST_LOAD;
        end
      end
      apg_pkg::ST_LOAD: begin
        cctl.load = 1'b1;
        iter_nxt  = '0;
        state_nxt = apg_pkg::ST_ITER;
      end
      apg_pkg::ST_ITER: begin
        cctl.step = 1'b1;
        iter_nxt  = iter_r + 1'b1;
        if (iter_r == apg_pkg::ITER_BITS'(apg_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = apg_pkg::ST_EMIT;
        end
      end
      apg_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit_fire = 1'b1;
          state_nxt = point_last ? apg_pkg::ST_IDLE : apg_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = apg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apg_pkg::ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r   <= '0;
      point_cnt_r <= '0;
    end else if (in_fire) begin
      mul_cnt_r   <= '0;
      point_cnt_r <= '0;
    end else begin
      if (state_r == apg_pkg::ST_MULT) begin
        mul_cnt_r <= mul_cnt_r + 1'b1;
      end
      if (emit_fire) begin
        point_cnt_r <= point_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mul_acc_r <= '0;
      mcand_r   <= PB'(apg_pkg::GAIN_Q30);
      mplier_r  <= radius_r;
      angle_r   <= AB'(in_start_angle) - AB'(half_span_r);
      cx_r      <= in_center_x;
      cy_r      <= in_center_y;
    end else begin
      if (state_r == apg_pkg::ST_MULT) begin
        if (mplier_r[0]) begin
          mul_acc_r <= mul_acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[PB-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[apg_pkg::RADIUS_BITS-1:1]};
      end
      if (emit_fire) begin
        angle_r <= angle_r + AB'(step_r);
      end
    end
  end

  apg_cordic u_cordic (
    .clk   (clk),
    .ctrl  (cctl),
    .gain  (mul_acc_r[PB-1:apg_pkg::GAIN_SHIFT]),
    .angle (angle_r + EIGHTH),
    .x_o   (cx_o),
    .y_o   (cy_o)
  );

  assign rx    = cx_o + ROUND_HALF;
  assign ry    = cy_o + ROUND_HALF;
  assign ox    = rx >>> apg_pkg::ROUND_BITS;
  assign oy    = ry >>> apg_pkg::ROUND_BITS;
  assign sum_x = $signed({ox[DW-1], ox}) + $signed({{(DW + 1 - CB){cx_r[CB-1]}}, cx_r});
  assign sum_y = $signed({oy[DW-1], oy}) + $signed({{(DW + 1 - CB){cy_r[CB-1]}}, cy_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_x_r    <= sat_coord(sum_x);
      out_y_r    <= sat_coord(sum_y);
      out_idx_r  <= point_cnt_r;
      out_last_r <= point_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_index = out_idx_r;
  assign out_last_point  = out_last_r;

  `APG_ASSERT_NEXT(a_accept_starts_mult, in_fire,
                   state_r == apg_pkg::ST_MULT && mul_cnt_r == '0,
                   "input beat did not start the gain multiply")
  `APG_ASSERT(a_index_in_run, !out_valid_r || out_idx_r <= last_idx,
              "point index beyond the end of the run")
  `APG_ASSERT(a_iter_bound, state_r != apg_pkg::ST_ITER ||
              iter_r < apg_pkg::ITER_BITS'(apg_pkg::CORDIC_STEPS),
              "CORDIC iteration count out of range")
  `APG_ASSERT_NEXT(a_last_ends_run, emit_fire && point_last,
                   state_r == apg_pkg::ST_IDLE && out_valid_r && out_last_r,
                   "final point did not end the run")
  `APG_ASSERT_NEXT(a_emit_stall, state_r == apg_pkg::ST_EMIT && out_valid_r && !out_ready,
                   state_r == apg_pkg::ST_EMIT,
                   "emit left while the output beat was still pending")

endmodule
`default_nettype wire
